>>> sv/wrlt_pkg.sv
package wrlt_pkg;

  // Widest window length register.
  localparam int WIN_BITS = 20;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int COUNT_W  = 24;
  localparam int THRESH_W = 16;

  // A square of a 16-bit sample needs 31 bits; a window adds WIN_BITS more.
  localparam int SQUARE_W = 2 * SAMPLE_W - 1;
  localparam int SUM_W    = SQUARE_W + WIN_BITS;

  // Top-bit index of a sum and the log2 result in Q16.
  localparam int FRAC_BITS = 16;
  localparam int EXP_W     = $clog2(SUM_W);
  localparam int LOG_W     = EXP_W + FRAC_BITS;
  localparam int ITER_W    = $clog2(FRAC_BITS);

  // Difference of two logs minus the full-scale offset, signed.
  localparam int DIFF_W = LOG_W + 2;

  // Mantissa is Q1.31; the shared multiplier is signed 33 by 33.
  localparam int MANT_W = 32;
  localparam int MUL_W  = MANT_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // Coarse step of the normalizer.
  localparam int NORM_STEP = 8;

  // 256*10*log10(2) and 256*3.0103, each in Q16.
  localparam longint LOG_SCALE  = 64'sd50504453;
  localparam longint OFFSET_Q16 = 64'sd50504453;
  localparam longint FULL_SCALE_LOG = 64'sd30 <<< FRAC_BITS;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LEVEL = 1'd1;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(480);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_L,
    S_SQ_R,
    S_ACC,
    S_LOG_LOAD,
    S_NORM,
    S_SQR_MUL,
    S_SQR_BIT,
    S_LVL_L,
    S_LVL_R,
    S_LVL_DONE,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SRC_LEFT,
    SRC_RIGHT,
    SRC_LEN
  } src_t;

endpackage

>>> sv/windowed_rms_level_threshold.sv
// Windowed RMS level meter for stereo 16-bit PCM. Each input item is one
// frame (left sample in tdata bits 15:0, right in 31:16). The square of each
// sample is added to a per-channel sum, and when the frame that completes a
// window of window_length frames arrives (a length of zero acts as one), the
// block emits one result item: both levels in 1/256 dB, computed as
// 10*log10(mean square) relative to full scale plus 3.0103 dB, saturated at
// -128 dB (a silent channel reads -128 dB), a flag set when either level is
// at or above threshold_level, and a saturating count of flagged windows.
// Frames of an unfinished window give no result. A frame that does not close
// a window passes through the idle, left square, right square and accumulate
// states, since both squares go through the one shared 33x33 multiplier. A
// frame that closes a window also runs three base-2 logarithms (left sum,
// right sum, frame count) through that multiplier, each with a load step,
// normalizing steps and squaring steps (a silent channel takes only the load
// step), then the dB scaling steps and a hand-over step.
// The hand-over stalls while an earlier result still waits in the output
// register.
// in_tready is low while a frame is being worked on; a finished result waits
// in the output register and does not hold up the next frame until the
// following window end. Configuration is to be written only while idle; the block itself does not enforce this.
module windowed_rms_level_threshold (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // left_sample[15:0], right_sample[31:16]

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // left_level[15:0], right_level[31:16],
                                  // over_count[55:32]
  output logic [0:0]  out_tuser,  // over_threshold[0]

  input  logic                                cfg_we,
  input  logic [wrlt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wrlt_pkg::WIN_BITS-1:0]       cfg_data
);

  localparam int SUM_W  = wrlt_pkg::SUM_W;
  localparam int LOG_W  = wrlt_pkg::LOG_W;
  localparam int EXP_W  = wrlt_pkg::EXP_W;
  localparam int MUL_W  = wrlt_pkg::MUL_W;
  localparam int PROD_W = wrlt_pkg::PROD_W;
  localparam int MANT_W = wrlt_pkg::MANT_W;
  localparam int DIFF_W = wrlt_pkg::DIFF_W;
  localparam int WIN_W  = wrlt_pkg::WIN_BITS;
  localparam int LVL_W  = wrlt_pkg::LEVEL_W;
  localparam int STEP   = wrlt_pkg::NORM_STEP;

  // Constant added after the scaling multiply: the 3.0103 dB offset moved to
  // Q32 plus one half for rounding.
  localparam logic signed [PROD_W-1:0] LEVEL_BIAS =
    PROD_W'((wrlt_pkg::OFFSET_Q16 <<< 16) + (64'sd1 <<< 31));
  localparam logic signed [MUL_W-1:0] SCALE_OP = MUL_W'(wrlt_pkg::LOG_SCALE);
  localparam logic signed [PROD_W-LVL_W*2-1:0] LVL_MAX =
    (PROD_W-LVL_W*2)'((64'sd1 <<< (LVL_W - 1)) - 1);
  localparam logic signed [PROD_W-LVL_W*2-1:0] LVL_MIN =
    (PROD_W-LVL_W*2)'(-(64'sd1 <<< (LVL_W - 1)));
  localparam logic signed [LVL_W-1:0] LVL_SILENT = LVL_MIN[LVL_W-1:0];
  localparam logic [wrlt_pkg::COUNT_W-1:0] COUNT_MAX = '1;

  // Turn a registered scaling product into a clamped level.
  function automatic logic signed [LVL_W-1:0] level_of(
    input logic signed [PROD_W-1:0] prod,
    input logic                     silent
  );
    logic signed [PROD_W-1:0]    v;
    logic signed [PROD_W-33:0]   fl;
    logic signed [LVL_W-1:0]     res;
    v  = prod + LEVEL_BIAS;
    fl = v[PROD_W-1:32];
    if (silent || fl < (PROD_W-32)'(LVL_MIN)) begin
      res = LVL_SILENT;
    end else if (fl > (PROD_W-32)'(LVL_MAX)) begin
      res = LVL_MAX[LVL_W-1:0];
    end else begin
      res = fl[LVL_W-1:0];
    end
    return res;
  endfunction

  wrlt_pkg::state_t state_r, state_nxt;
  wrlt_pkg::src_t   src_r, src_nxt;

  logic [WIN_W-1:0]    window_length_r, window_length_nxt;
  logic signed [wrlt_pkg::THRESH_W-1:0] threshold_r, threshold_nxt;

  logic signed [wrlt_pkg::SAMPLE_W-1:0] left_r, left_nxt;
  logic signed [wrlt_pkg::SAMPLE_W-1:0] right_r, right_nxt;
  logic [SUM_W-1:0]    lsum_r, lsum_nxt;
  logic [SUM_W-1:0]    rsum_r, rsum_nxt;
  logic [WIN_W-1:0]    frame_count_r, frame_count_nxt;
  logic [WIN_W-1:0]    frames_r, frames_nxt;

  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]    norm_r, norm_nxt;
  logic [EXP_W-1:0]    exp_r, exp_nxt;
  logic [MANT_W-1:0]   mant_r, mant_nxt;
  logic [LOG_W-1:0]    log_acc_r, log_acc_nxt;
  logic [wrlt_pkg::ITER_W-1:0] iter_r, iter_nxt;

  logic [LOG_W-1:0]    log_l_r, log_l_nxt;
  logic [LOG_W-1:0]    log_r_r, log_r_nxt;
  logic [LOG_W-1:0]    log_n_r, log_n_nxt;
  logic                silent_l_r, silent_l_nxt;
  logic                silent_r_r, silent_r_nxt;
  logic signed [LVL_W-1:0] lvl_l_r, lvl_l_nxt;

  // Right level held from the scaling step until it can be sent.
  logic signed [LVL_W-1:0] lvl_r_lat_r, lvl_r_lat_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic signed [LVL_W-1:0] out_left_r, out_left_nxt;
  logic signed [LVL_W-1:0] out_right_r, out_right_nxt;
  logic                out_over_r, out_over_nxt;
  logic [wrlt_pkg::COUNT_W-1:0] count_r, count_nxt;

  // Shared multiplier operands.
  logic signed [MUL_W-1:0]  mul_a, mul_b;

  // Combinational helpers.
  logic [WIN_W:0]            frame_next;
  logic [WIN_W-1:0]          eff_len;
  logic [SUM_W-1:0]          load_val;
  logic [MANT_W:0]           sq_top;
  logic signed [DIFF_W-1:0]  diff_l, diff_r;
  logic signed [LVL_W-1:0]   lvl_r_now;

  assign frame_next = {1'b0, frame_count_r} + (WIN_W+1)'(1);
  assign eff_len    = (window_length_r == '0) ? WIN_W'(1) : window_length_r;
  assign sq_top     = prod_r[2*MANT_W-1:MANT_W-1];

  assign diff_l = DIFF_W'(log_l_r) - DIFF_W'(log_n_r)
                  - DIFF_W'(wrlt_pkg::FULL_SCALE_LOG);
  assign diff_r = DIFF_W'(log_r_r) - DIFF_W'(log_n_r)
                  - DIFF_W'(wrlt_pkg::FULL_SCALE_LOG);

  assign lvl_r_now = level_of(prod_r, silent_r_r);

  always_comb begin
    case (src_r)
      wrlt_pkg::SRC_LEFT:  load_val = lsum_r;
      wrlt_pkg::SRC_RIGHT: load_val = rsum_r;
      wrlt_pkg::SRC_LEN:   load_val = SUM_W'(frames_r);
      default:             load_val = SUM_W'(frames_r);
    endcase
  end

  always_comb begin
    state_nxt         = state_r;
    src_nxt           = src_r;
    window_length_nxt = window_length_r;
    threshold_nxt     = threshold_r;
    left_nxt          = left_r;
    right_nxt         = right_r;
    lsum_nxt          = lsum_r;
    rsum_nxt          = rsum_r;
    frame_count_nxt   = frame_count_r;
    frames_nxt        = frames_r;
    norm_nxt          = norm_r;
    exp_nxt           = exp_r;
    mant_nxt          = mant_r;
    log_acc_nxt       = log_acc_r;
    iter_nxt          = iter_r;
    log_l_nxt         = log_l_r;
    log_r_nxt         = log_r_r;
    log_n_nxt         = log_n_r;
    silent_l_nxt      = silent_l_r;
    silent_r_nxt      = silent_r_r;
    lvl_l_nxt         = lvl_l_r;
    out_valid_nxt     = out_valid_r;
    out_left_nxt      = out_left_r;
    out_right_nxt     = out_right_r;
    out_over_nxt      = out_over_r;
    count_nxt         = count_r;
    mul_a             = '0;
    mul_b             = '0;
    in_tready         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        wrlt_pkg::REG_WINDOW_LENGTH:   window_length_nxt = cfg_data;
        wrlt_pkg::REG_THRESHOLD_LEVEL: threshold_nxt = cfg_data[wrlt_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      wrlt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          left_nxt  = in_tdata[wrlt_pkg::SAMPLE_W-1:0];
          right_nxt = in_tdata[2*wrlt_pkg::SAMPLE_W-1:wrlt_pkg::SAMPLE_W];
          state_nxt = wrlt_pkg::S_SQ_L;
        end
      end

      wrlt_pkg::S_SQ_L: begin
        mul_a     = MUL_W'(left_r);
        mul_b     = MUL_W'(left_r);
        state_nxt = wrlt_pkg::S_SQ_R;
      end

      wrlt_pkg::S_SQ_R: begin
        lsum_nxt  = lsum_r + SUM_W'(prod_r[wrlt_pkg::SQUARE_W-1:0]);
        mul_a     = MUL_W'(right_r);
        mul_b     = MUL_W'(right_r);
        state_nxt = wrlt_pkg::S_ACC;
      end

      wrlt_pkg::S_ACC: begin
        rsum_nxt = rsum_r + SUM_W'(prod_r[wrlt_pkg::SQUARE_W-1:0]);
        if (frame_next < (WIN_W+1)'(eff_len)) begin
          frame_count_nxt = frame_next[WIN_W-1:0];
          state_nxt       = wrlt_pkg::S_IDLE;
        end else begin
          // The window closes; the mean divides by the frames really summed.
          frames_nxt = frame_next[WIN_W-1:0];
          src_nxt    = wrlt_pkg::SRC_LEFT;
          state_nxt  = wrlt_pkg::S_LOG_LOAD;
        end
      end

      wrlt_pkg::S_LOG_LOAD: begin
        norm_nxt = load_val;
        exp_nxt  = EXP_W'(SUM_W - 1);
        if (load_val == '0) begin
          // A silent channel needs no logarithm.
          if (src_r == wrlt_pkg::SRC_LEFT) begin
            silent_l_nxt = 1'b1;
            src_nxt      = wrlt_pkg::SRC_RIGHT;
          end else begin
            silent_r_nxt = 1'b1;
            src_nxt      = wrlt_pkg::SRC_LEN;
          end
        end else begin
          if (src_r == wrlt_pkg::SRC_LEFT) begin
            silent_l_nxt = 1'b0;
          end else if (src_r == wrlt_pkg::SRC_RIGHT) begin
            silent_r_nxt = 1'b0;
          end
          state_nxt = wrlt_pkg::S_NORM;
        end
      end

      wrlt_pkg::S_NORM: begin
        // Move the top set bit to the MSB, eight places or one at a time.
        if (norm_r[SUM_W-1 -: STEP] == '0) begin
          norm_nxt = norm_r << STEP;
          exp_nxt  = exp_r - EXP_W'(STEP);
        end else if (!norm_r[SUM_W-1]) begin
          norm_nxt = norm_r << 1;
          exp_nxt  = exp_r - EXP_W'(1);
        end else begin
          mant_nxt    = norm_r[SUM_W-1 -: MANT_W];
          log_acc_nxt = LOG_W'(exp_r);
          iter_nxt    = '0;
          state_nxt   = wrlt_pkg::S_SQR_MUL;
        end
      end

      wrlt_pkg::S_SQR_MUL: begin
        mul_a     = MUL_W'({1'b0, mant_r});
        mul_b     = MUL_W'({1'b0, mant_r});
        state_nxt = wrlt_pkg::S_SQR_BIT;
      end

      wrlt_pkg::S_SQR_BIT: begin
        // Squaring the mantissa doubles its log; a carry past 2.0 is the
        // next fraction bit.
        if (sq_top[MANT_W]) begin
          mant_nxt = sq_top[MANT_W:1];
        end else begin
          mant_nxt = sq_top[MANT_W-1:0];
        end
        log_acc_nxt = {log_acc_r[LOG_W-2:0], sq_top[MANT_W]};
        iter_nxt    = iter_r + wrlt_pkg::ITER_W'(1);
        state_nxt   = wrlt_pkg::S_SQR_MUL;
        if (iter_r == wrlt_pkg::ITER_W'(wrlt_pkg::FRAC_BITS - 1)) begin
          case (src_r)
            wrlt_pkg::SRC_LEFT: begin
              log_l_nxt = {log_acc_r[LOG_W-2:0], sq_top[MANT_W]};
              src_nxt   = wrlt_pkg::SRC_RIGHT;
              state_nxt = wrlt_pkg::S_LOG_LOAD;
            end
            wrlt_pkg::SRC_RIGHT: begin
              log_r_nxt = {log_acc_r[LOG_W-2:0], sq_top[MANT_W]};
              src_nxt   = wrlt_pkg::SRC_LEN;
              state_nxt = wrlt_pkg::S_LOG_LOAD;
            end
            default: begin
              log_n_nxt = {log_acc_r[LOG_W-2:0], sq_top[MANT_W]};
              state_nxt = wrlt_pkg::S_LVL_L;
            end
          endcase
        end
      end

      wrlt_pkg::S_LVL_L: begin
        mul_a     = MUL_W'(diff_l);
        mul_b     = SCALE_OP;
        state_nxt = wrlt_pkg::S_LVL_R;
      end

      wrlt_pkg::S_LVL_R: begin
        lvl_l_nxt = level_of(prod_r, silent_l_r);
        mul_a     = MUL_W'(diff_r);
        mul_b     = SCALE_OP;
        state_nxt = wrlt_pkg::S_LVL_DONE;
      end

      wrlt_pkg::S_LVL_DONE: begin
        // The right level is latched into lvl_r_lat_r in this cycle.
        state_nxt = wrlt_pkg::S_EMIT;
      end

      wrlt_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = lvl_l_r;
          out_over_nxt  = (lvl_l_r >= threshold_r) || (lvl_r_lat_r >= threshold_r);
          out_right_nxt = lvl_r_lat_r;
          if (((lvl_l_r >= threshold_r) || (lvl_r_lat_r >= threshold_r))
              && count_r != COUNT_MAX) begin
            count_nxt = count_r + wrlt_pkg::COUNT_W'(1);
          end
          lsum_nxt        = '0;
          rsum_nxt        = '0;
          frame_count_nxt = '0;
          state_nxt       = wrlt_pkg::S_IDLE;
        end
      end

      default: state_nxt = wrlt_pkg::S_IDLE;
    endcase
  end

  assign lvl_r_lat_nxt = (state_r == wrlt_pkg::S_LVL_DONE) ? lvl_r_now : lvl_r_lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= wrlt_pkg::S_IDLE;
      src_r           <= wrlt_pkg::SRC_LEFT;
      window_length_r <= wrlt_pkg::WINDOW_RESET;
      threshold_r     <= '0;
      lsum_r          <= '0;
      rsum_r          <= '0;
      frame_count_r   <= '0;
      count_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      src_r           <= src_nxt;
      window_length_r <= window_length_nxt;
      threshold_r     <= threshold_nxt;
      lsum_r          <= lsum_nxt;
      rsum_r          <= rsum_nxt;
      frame_count_r   <= frame_count_nxt;
      count_r         <= count_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    frames_r    <= frames_nxt;
    prod_r      <= mul_a * mul_b;
    norm_r      <= norm_nxt;
    exp_r       <= exp_nxt;
    mant_r      <= mant_nxt;
    log_acc_r   <= log_acc_nxt;
    iter_r      <= iter_nxt;
    log_l_r     <= log_l_nxt;
    log_r_r     <= log_r_nxt;
    log_n_r     <= log_n_nxt;
    silent_l_r  <= silent_l_nxt;
    silent_r_r  <= silent_r_nxt;
    lvl_l_r     <= lvl_l_nxt;
    lvl_r_lat_r <= lvl_r_lat_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_over_r  <= out_over_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {count_r, out_right_r, out_left_r};
  assign out_tuser  = out_over_r;

endmodule
